@@ rtl/sssp_pkg.sv @@
// Shared constants and controller/datapath interface types for the shortest path core.
package sssp_pkg;

  localparam int NODES_DEF       = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int NODE_ID_W   = 7;
  localparam int WEIGHT_IN_W = 16;
  localparam int LEN_W       = 22;
  localparam int CFG_W       = 7;

  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 32;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_RUN      = 1'b1;

  typedef struct packed {
    logic clr_wr;      // clearing pass: write a blank edge entry
    logic accept;      // latch the input item
    logic edge_upd;    // add edge: compare and write back
    logic run_init;    // clear flags, seed the source
    logic idx_clr;
    logic idx_inc;
    logic issue;       // node index enters the read pipe
    logic relax_rd;    // pipe carries a relax pass, else a min scan
    logic scan_start;  // clear the running minimum
    logic settle;      // mark the picked node settled
    logic out_load;    // load the result register
  } sssp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cmd_run;
    logic idx_last;
    logic found;
  } sssp_sts_t;

endpackage

@@ rtl/single_source_shortest_path_core.sv @@
// Top level of the single-source shortest path core: controller, datapath and checks.
//
// Items on the input stream either add a weighted directed edge (keeping the smaller weight
// of a repeated edge) or run a shortest path search from a source node, after which one
// result item per node 1..node_count comes out in node order, tlast on the final node.
// After reset the edge store is swept clean, one entry a cycle, over all 2^(2*ceil(log2(NODES)))
// entries (4096 at 64 nodes); no item is taken until the sweep ends, while configuration
// writes are taken at any time. An add edge item is a read-modify-write of the edge store.
// A run's search is bounded by the single read port of the distance store, which both the
// min scan and the relax pass walk one node a cycle; the results then go out one at a time,
// each waiting for the output side. One item is worked on at a time.
module single_source_shortest_path_core #(
  parameter int NODES       = sssp_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sssp_pkg::CFG_W-1:0]      cfg_wdata,   // node_count
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // from_node[6:0], to_node[13:7], edge_weight[29:14], source_node[36:30]
  input  logic [sssp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,    // command[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // node_id[6:0], path_length[28:7]
  output logic [sssp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tuser,   // reached[0]
  output logic                            out_tlast
);

  sssp_pkg::sssp_cmd_t cmd;
  sssp_pkg::sssp_sts_t sts;

  sssp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sssp_dpath #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

  // no new item while a result is pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a result is pending");

  // final result taken returns the block to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not idle after final result");

  // unreached node reports zero length
  a_unreached_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[28:7] == '0))
    else $error("unreached node with nonzero length");

  // edge update is a fixed read-modify-write and emits nothing
  a_edge_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == sssp_pkg::CMD_ADD_EDGE)) |=>
      (!in_tready && !out_tvalid) ##1 (!in_tready && !out_tvalid) ##1 in_tready)
    else $error("edge update sequence broken");

endmodule

@@ rtl/sssp_ctrl.sv @@
// Sequencer for the shortest path core: clearing pass, edge update, scan/relax loop, result output.
module sssp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  sssp_pkg::sssp_sts_t sts,
  output sssp_pkg::sssp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_INIT,
    S_SCAN,
    S_SCAN_END,
    S_SCAN_CHK,
    S_RELAX,
    S_RELAX_END,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    cmd            = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = (sts.cmd_run == sssp_pkg::CMD_RUN) ? S_INIT : S_EDGE_RD;
        end
      end
      S_EDGE_RD: state_nxt = S_EDGE_WR;
      S_EDGE_WR: begin
        cmd.edge_upd = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_INIT: begin
        cmd.run_init   = 1'b1;
        cmd.idx_clr    = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        cmd.issue   = 1'b1;
        cmd.idx_inc = 1'b1;
        if (sts.idx_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        cmd.idx_clr = 1'b1;
        if (sts.found) begin
          cmd.settle = 1'b1;
          state_nxt  = S_RELAX;
        end else begin
          state_nxt = S_OUT_RD;
        end
      end
      S_RELAX: begin
        cmd.issue    = 1'b1;
        cmd.relax_rd = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (sts.idx_last) state_nxt = S_RELAX_END;
      end
      S_RELAX_END: begin
        cmd.idx_clr    = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_OUT_RD: state_nxt = S_OUT_LD;
      S_OUT_LD: begin
        cmd.out_load   = 1'b1;
        out_tvalid_nxt = 1'b1;
        state_nxt      = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_tready) begin
          out_tvalid_nxt = 1'b0;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

endmodule

@@ rtl/sssp_dpath.sv @@
// Datapath of the shortest path core: edge store, distance store, node flags, min scan and relax.
module sssp_dpath #(
  parameter int NODES       = sssp_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sssp_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [sssp_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  output logic [sssp_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  sssp_pkg::sssp_cmd_t               cmd,
  output sssp_pkg::sssp_sts_t               sts
);

  localparam int NODE_BITS  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int EADDR_BITS = 2 * NODE_BITS;
  localparam int EDGE_DEPTH = 1 << EADDR_BITS;
  localparam int DIST_BITS  = WEIGHT_BITS + NODE_BITS;
  localparam int EDGE_W     = WEIGHT_BITS + 1;
  localparam logic [32:0] WMAX = (33'd1 << WEIGHT_BITS) - 33'd1;

  // input fields
  logic [sssp_pkg::NODE_ID_W-1:0]   in_from, in_to, in_src;
  logic [sssp_pkg::WEIGHT_IN_W-1:0] in_w;
  assign in_from = in_tdata[6:0];
  assign in_to   = in_tdata[13:7];
  assign in_w    = in_tdata[29:14];
  assign in_src  = in_tdata[36:30];

  logic [sssp_pkg::CFG_W-1:0] node_count_r;
  logic [NODE_BITS-1:0]       from_idx_r, to_idx_r, src_idx_r, cnt_m1_r;
  logic [WEIGHT_BITS-1:0]     w_r;
  logic                       edge_ok_r, src_ok_r;

  logic [31:0] act32, from_m1, to_m1, src_m1, w32, w_sat;
  always_comb begin
    if (node_count_r == '0) act32 = 32'd1;
    else if (32'(node_count_r) > 32'(NODES)) act32 = 32'(NODES);
    else act32 = 32'(node_count_r);
    from_m1 = 32'(in_from) - 32'd1;
    to_m1   = 32'(in_to) - 32'd1;
    src_m1  = 32'(in_src) - 32'd1;
    w32     = 32'(in_w);
    w_sat   = (w32 > WMAX[31:0]) ? WMAX[31:0] : w32;
  end

  logic [31:0] act_m1;
  assign act_m1 = act32 - 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= sssp_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      from_idx_r <= from_m1[NODE_BITS-1:0];
      to_idx_r   <= to_m1[NODE_BITS-1:0];
      src_idx_r  <= src_m1[NODE_BITS-1:0];
      w_r        <= w_sat[WEIGHT_BITS-1:0];
      edge_ok_r  <= (in_from != '0) && (32'(in_from) <= 32'(NODES)) &&
                    (in_to != '0) && (32'(in_to) <= 32'(NODES));
      src_ok_r   <= (in_src != '0) && (32'(in_src) <= act32);
      cnt_m1_r   <= act_m1[NODE_BITS-1:0];
    end
  end

  // node index counter and clearing pass address
  logic [NODE_BITS-1:0]  idx_r;
  logic [EADDR_BITS-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // read pipe: one stage behind the issued index
  logic                 pipe_vld_r, pipe_relax_r;
  logic [NODE_BITS-1:0] pipe_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_vld_r   <= 1'b0;
      pipe_relax_r <= 1'b0;
    end else begin
      pipe_vld_r   <= cmd.issue;
      pipe_relax_r <= cmd.relax_rd;
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx_r <= idx_r;
  end

  // edge store: valid bit over weight
  logic [EDGE_W-1:0]     edge_mem [0:EDGE_DEPTH-1];
  logic [EDGE_W-1:0]     edge_rdata_r;
  logic [NODE_BITS-1:0]  pick_r;
  logic [EADDR_BITS-1:0] edge_raddr, edge_slot;
  logic                  edge_wr;

  assign edge_slot  = {from_idx_r, to_idx_r};
  assign edge_raddr = cmd.relax_rd ? {pick_r, idx_r} : edge_slot;
  assign edge_wr    = cmd.edge_upd && edge_ok_r &&
                      (!edge_rdata_r[WEIGHT_BITS] || (w_r < edge_rdata_r[WEIGHT_BITS-1:0]));

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) edge_mem[clr_addr_r] <= '0;
    else if (edge_wr) edge_mem[edge_slot] <= {1'b1, w_r};
    edge_rdata_r <= edge_mem[edge_raddr];
  end

  // distance store, read at the node counter every cycle
  logic [DIST_BITS-1:0] dist_mem [0:NODES-1];
  logic [DIST_BITS-1:0] dist_rdata_r;
  logic [DIST_BITS-1:0] min_r, cand;
  logic [NODES-1:0]     known_r, settled_r;
  logic                 found_r;
  logic                 relax_upd, scan_take;
  logic                 dist_we;
  logic [NODE_BITS-1:0] dist_waddr;
  logic [DIST_BITS-1:0] dist_wdata;

  assign cand      = min_r + DIST_BITS'(edge_rdata_r[WEIGHT_BITS-1:0]);
  assign relax_upd = pipe_vld_r && pipe_relax_r && edge_rdata_r[WEIGHT_BITS] &&
                     (!known_r[pipe_idx_r] || (cand < dist_rdata_r));
  assign scan_take = pipe_vld_r && !pipe_relax_r && known_r[pipe_idx_r] &&
                     !settled_r[pipe_idx_r] && (!found_r || (dist_rdata_r < min_r));

  always_comb begin
    if (cmd.run_init) begin
      dist_we    = src_ok_r;
      dist_waddr = src_idx_r;
      dist_wdata = '0;
    end else begin
      dist_we    = relax_upd;
      dist_waddr = pipe_idx_r;
      dist_wdata = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rdata_r <= dist_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r   <= '0;
      settled_r <= '0;
      found_r   <= 1'b0;
    end else begin
      if (cmd.run_init) begin
        // only the source starts out known
        known_r   <= src_ok_r ? (NODES'(1) << src_idx_r) : '0;
        settled_r <= '0;
      end else begin
        if (cmd.settle) settled_r[pick_r] <= 1'b1;
        if (relax_upd) known_r[pipe_idx_r] <= 1'b1;
      end
      if (cmd.scan_start) found_r <= 1'b0;
      else if (scan_take) found_r <= 1'b1;
    end
  end

  // running minimum; strict compare keeps the lowest node on ties
  always_ff @(posedge clk) begin
    if (scan_take) begin
      min_r  <= dist_rdata_r;
      pick_r <= pipe_idx_r;
    end
  end

  // result register
  logic [NODE_BITS+7:0]           nid_w;
  logic [DIST_BITS+21:0]          len_w;
  logic [sssp_pkg::NODE_ID_W-1:0] out_node_r;
  logic [sssp_pkg::LEN_W-1:0]     out_len_r;
  logic                           out_reached_r, out_last_r;
  logic                           idx_last;

  assign nid_w    = {8'b0, idx_r} + (NODE_BITS+8)'(1);
  assign len_w    = {22'b0, dist_rdata_r};
  assign idx_last = (idx_r == cnt_m1_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_node_r    <= nid_w[sssp_pkg::NODE_ID_W-1:0];
      out_len_r     <= known_r[idx_r] ? len_w[sssp_pkg::LEN_W-1:0] : '0;
      out_reached_r <= known_r[idx_r];
      out_last_r    <= idx_last;
    end
  end

  assign out_tdata = {3'b0, out_len_r, out_node_r};
  assign out_tuser = out_reached_r;
  assign out_tlast = out_last_r;

  assign sts.clr_last = &clr_addr_r;
  assign sts.cmd_run  = in_tuser;
  assign sts.idx_last = idx_last;
  assign sts.found    = found_r;

endmodule
